// ----- hdl/apv_pkg.sv -----
package apv_pkg;

   localparam int LENGTH_LIMIT = 4095;
   localparam int MAX_LEN_W    = 12;
   // Count saturates at LENGTH_LIMIT + 1, so it needs room for that value.
   localparam int COUNT_W      = $clog2(LENGTH_LIMIT + 2);
   localparam int CMP_W        = (COUNT_W > MAX_LEN_W) ? COUNT_W : MAX_LEN_W;
   localparam int CP_W         = 21;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_SLASH = 8'h2f;
   localparam logic [7:0] CHAR_DOT   = 8'h2e;

   localparam logic [7:0] LEAD2_LO = 8'hc2;
   localparam logic [7:0] LEAD2_HI = 8'hdf;
   localparam logic [7:0] LEAD3_LO = 8'he0;
   localparam logic [7:0] LEAD3_HI = 8'hef;
   localparam logic [7:0] LEAD4_LO = 8'hf0;
   localparam logic [7:0] LEAD4_HI = 8'hf4;
   localparam logic [1:0] CONT_TAG = 2'b10;

   localparam logic [1:0] CLASS_2B = 2'd1;
   localparam logic [1:0] CLASS_3B = 2'd2;
   localparam logic [1:0] CLASS_4B = 2'd3;

   localparam logic [CP_W-1:0] FLOOR_2B  = 21'h00080;
   localparam logic [CP_W-1:0] FLOOR_3B  = 21'h00800;
   localparam logic [CP_W-1:0] FLOOR_4B  = 21'h10000;
   localparam logic [CP_W-1:0] CP_MAX    = 21'h10ffff;
   localparam logic [CP_W-1:0] SURR_LO   = 21'h0d800;
   localparam logic [CP_W-1:0] SURR_HI   = 21'h0dfff;

   localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 12'd4095;

   typedef struct packed {
      logic [COUNT_W-1:0] bytes_seen;
      logic               rejected;
      logic [1:0]         cont_left;
      logic [CP_W-1:0]    cp_acc;
      logic [1:0]         ovl_class;
      logic [1:0]         seg_len;
      logic               seg_dots;
   } apv_state_type;

   localparam apv_state_type STATE_CLEAR = '{
      bytes_seen: '0, rejected: 1'b0, cont_left: 2'd0, cp_acc: '0,
      ovl_class: 2'd0, seg_len: 2'd0, seg_dots: 1'b1
   };

endpackage

// ----- hdl/apv_step.sv -----
module apv_step (
   input  apv_pkg::apv_state_type           cur,
   input  logic [7:0]                       path_byte,
   input  logic                             final_byte,
   input  logic [apv_pkg::MAX_LEN_W-1:0]    max_length,
   output apv_pkg::apv_state_type           nxt,
   output logic                             path_ok
);
   import apv_pkg::*;

   apv_state_type         s;
   logic [CP_W-1:0]       cp_floor;
   logic [CP_W-1:0]       acc_shift;
   logic [CMP_W-1:0]      limit_w;
   logic [CMP_W-1:0]      count_w;
   logic                  seg_bad_cur;
   logic                  seg_bad_new;

   assign acc_shift   = {cur.cp_acc[CP_W-7:0], path_byte[5:0]};
   assign seg_bad_cur = (cur.seg_len == 2'd0) || (cur.seg_dots && cur.seg_len <= 2'd2);

   always_comb begin
      case (cur.ovl_class)
         CLASS_2B: cp_floor = FLOOR_2B;
         CLASS_3B: cp_floor = FLOOR_3B;
         default:  cp_floor = FLOOR_4B;
      endcase
   end

   always_comb begin
      limit_w = CMP_W'(max_length);
      if (limit_w > CMP_W'(LENGTH_LIMIT)) begin
         limit_w = CMP_W'(LENGTH_LIMIT);
      end
   end

   always_comb begin
      s = cur;
      if (cur.cont_left != 2'd0) begin
         if (path_byte[7:6] != CONT_TAG) begin
            s.rejected  = 1'b1;
            s.cont_left = 2'd0;
         end else begin
            s.cp_acc    = acc_shift;
            s.cont_left = cur.cont_left - 2'd1;
            if (cur.cont_left == 2'd1) begin
               if (acc_shift < cp_floor || acc_shift > CP_MAX ||
                   (acc_shift >= SURR_LO && acc_shift <= SURR_HI)) begin
                  s.rejected = 1'b1;
               end
            end
         end
      end else begin
         if (cur.bytes_seen == '0 && path_byte != CHAR_SLASH) begin
            s.rejected = 1'b1;
         end
         if (path_byte == CHAR_NUL || path_byte == CHAR_CR || path_byte == CHAR_LF) begin
            s.rejected = 1'b1;
         end
         if (path_byte == CHAR_SLASH) begin
            if (cur.bytes_seen != '0 && seg_bad_cur) begin
               s.rejected = 1'b1;
            end
            s.seg_len  = 2'd0;
            s.seg_dots = 1'b1;
         end else begin
            if (cur.seg_len != 2'd3) begin
               s.seg_len = cur.seg_len + 2'd1;
            end
            if (path_byte != CHAR_DOT) begin
               s.seg_dots = 1'b0;
            end
            if (path_byte[7]) begin
               if (path_byte >= LEAD2_LO && path_byte <= LEAD2_HI) begin
                  s.cont_left = 2'd1;
                  s.cp_acc    = CP_W'(path_byte[4:0]);
                  s.ovl_class = CLASS_2B;
               end else if (path_byte >= LEAD3_LO && path_byte <= LEAD3_HI) begin
                  s.cont_left = 2'd2;
                  s.cp_acc    = CP_W'(path_byte[3:0]);
                  s.ovl_class = CLASS_3B;
               end else if (path_byte >= LEAD4_LO && path_byte <= LEAD4_HI) begin
                  s.cont_left = 2'd3;
                  s.cp_acc    = CP_W'(path_byte[2:0]);
                  s.ovl_class = CLASS_4B;
               end else begin
                  s.rejected = 1'b1;
               end
            end
         end
      end
      // saturate the byte count one past the hard limit
      if (cur.bytes_seen <= COUNT_W'(LENGTH_LIMIT)) begin
         s.bytes_seen = cur.bytes_seen + COUNT_W'(1);
      end
   end

   assign count_w     = CMP_W'(s.bytes_seen);
   assign seg_bad_new = (s.seg_len == 2'd0) || (s.seg_dots && s.seg_len <= 2'd2);

   always_comb begin
      nxt = s;
      if (count_w > limit_w) begin
         nxt.rejected = 1'b1;
      end
      path_ok = !nxt.rejected && (count_w >= CMP_W'(2)) && (path_byte != CHAR_SLASH) &&
                (nxt.cont_left == 2'd0) && !seg_bad_new;
      if (final_byte) begin
         nxt = STATE_CLEAR;
      end
   end

endmodule

// ----- hdl/apv_out.sv -----
module apv_out (
   input  logic clock,
   input  logic reset,
   input  logic load,
   input  logic load_ok,
   output logic full,
   input  logic take,
   output logic path_ok
);
   import apv_pkg::*;

   logic valid_ff, valid_in;
   logic ok_ff, ok_in;

   always_comb begin
      valid_in = valid_ff;
      ok_in    = ok_ff;
      if (take) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         ok_in    = load_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      ok_ff <= ok_in;
   end

   assign full    = valid_ff;
   assign path_ok = ok_ff;

endmodule

// ----- hdl/absolute_path_utf8_validator.sv -----
// Channel  Direction  Word fields (low bit first)       Handshake
// req      in         tdata[7:0] path_byte, tlast final  tvalid/tready
// rsp      out        tdata[0] path_ok, [7:1] zero       tvalid/tready
// csr      in         wdata[11:0] max_length             we, no wait
//
// One byte per cycle sustained unless a final byte waits on a held verdict; a
// verdict turns valid once its final byte leaves the input register and loads it.
// Bytes pass an input register, then combinational path and UTF-8 update logic
// writes the running state and, on the final byte, the verdict register.
// Synchronous reset empties both registers, clears the path state and sets
// max_length to 4095. Only a final byte waits on a full verdict register;
// other bytes keep flowing while a verdict is held.
module absolute_path_utf8_validator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,  // [7:0] path_byte
   input  logic                           req_tlast,  // final_byte
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,  // [0] path_ok, [7:1] zero
   input  logic                           csr_we,
   input  logic [apv_pkg::MAX_LEN_W-1:0]  csr_wdata   // max_length
);
   import apv_pkg::*;

   // configuration register
   logic [MAX_LEN_W-1:0] max_len_ff, max_len_in;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_last_ff, in_last_in;

   // running path state
   apv_state_type st_ff, st_in, st_next;

   logic step_ok;
   logic out_full;
   logic advance;
   logic req_fire;

   assign max_len_in = csr_we ? csr_wdata : max_len_ff;

   // advance the held word unless it is a final byte blocked by a waiting verdict
   assign advance    = in_valid_ff && (!in_last_ff || !out_full || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
         in_last_in  = req_tlast;
      end
   end

   apv_step u_step (
      .cur        (st_ff),
      .path_byte  (in_byte_ff),
      .final_byte (in_last_ff),
      .max_length (max_len_ff),
      .nxt        (st_next),
      .path_ok    (step_ok)
   );

   // hold state between words; step logic clears it after a final byte
   assign st_in = advance ? st_next : st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff  <= MAX_LEN_RESET;
         in_valid_ff <= 1'b0;
         st_ff       <= STATE_CLEAR;
      end else begin
         max_len_ff  <= max_len_in;
         in_valid_ff <= in_valid_in;
         st_ff       <= st_in;
      end
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
   end

   logic rsp_ok;

   apv_out u_out (
      .clock   (clock),
      .reset   (reset),
      .load    (advance && in_last_ff),
      .load_ok (step_ok),
      .full    (out_full),
      .take    (rsp_tready),
      .path_ok (rsp_ok)
   );

   assign rsp_tvalid = out_full;
   assign rsp_tdata  = {7'd0, rsp_ok};

endmodule
